// ===== sv/spectral_flux_onset_detector_assert.svh =====
// assertion macros for the spectral flux onset detector
`ifndef SPECTRAL_FLUX_ONSET_DETECTOR_ASSERT_SVH
`define SPECTRAL_FLUX_ONSET_DETECTOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFOD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SFOD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sfod_pkg.sv =====
// shared types and constants of the spectral flux onset detector
package sfod_pkg;

	localparam int unsigned DEF_BANDS  = 512;
	localparam int unsigned DEF_WINDOW = 64;

	localparam int unsigned MAG_W      = 16;
	localparam int unsigned FLUX_W     = 25;
	localparam int unsigned SCALE_W    = 12;
	localparam int unsigned BLOW_W     = 9;
	localparam int unsigned BHIGH_W    = 10;
	localparam int unsigned SCALE_FRAC = 8;

	localparam logic [FLUX_W-1:0] FLUX_MAX = 25'd33553920;

	localparam int unsigned CFG_W     = 12;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [SCALE_W-1:0] SCALE_RST     = 12'd256;
	localparam logic [BLOW_W-1:0]  BAND_LOW_RST  = 9'd307;
	localparam logic [BHIGH_W-1:0] BAND_HIGH_RST = 10'd460;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE     = 2'd0,
		CFG_BAND_LOW  = 2'd1,
		CFG_BAND_HIGH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [MAG_W-1:0] band_magnitude;
		logic             last_band;
	} band_item_t;

	typedef struct packed {
		logic              beat;
		logic [FLUX_W-1:0] flux_value;
		logic [FLUX_W-1:0] threshold_value;
	} onset_result_t;

endpackage

// ===== sv/sfod_stream_if.sv =====
// valid/ready stream channel carrying one item payload
interface sfod_stream_if #(
	parameter type data_t = logic
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/spectral_flux_onset_detector.sv =====
// spectral flux onset detector: band stream in, per-frame onset result out
//
// band channel: one spectrum band magnitude per item, in band order, last_band on the
// final band of a frame. onset channel: one item per frame, sent for each band item
// that carries last_band, holding beat, the frame flux and the threshold.
// configuration: write cfg_data to register cfg_index when cfg_wr_en is high;
// index 0 threshold scale (q4.8), 1 first band, 2 one past the last band.
// throughput: one band item per cycle unless stalled or clearing, set by the single
// read-modify-write per item on the previous-spectrum memory (read at accept, written
// back from the stage 1 registers, with bypass). result: the frame's last band item
// passes the stage 1 to 4 registers and the output register on its way to onset.valid
// (spectrum diff, ring update, scale multiply, compare). reset: arst_n clears control
// state, then a clearing pass zeroes the spectrum memory and the flux ring; band.ready
// stays low meanwhile, configuration writes are taken as ever.
// stall: the output register holds a result while onset.ready is low; band items keep
// flowing until a second result reaches the last stage, which then holds the pipeline.
// WINDOW must be a power of two: the ring mean is a shift of the running sum.
`include "spectral_flux_onset_detector_assert.svh"

module spectral_flux_onset_detector #(
	parameter int unsigned BANDS  = sfod_pkg::DEF_BANDS,
	parameter int unsigned WINDOW = sfod_pkg::DEF_WINDOW
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [sfod_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfod_pkg::CFG_W-1:0]     cfg_data,
	sfod_stream_if.sink                    band,
	sfod_stream_if.source                  onset
);
	import sfod_pkg::*;

	localparam int unsigned CNT_W   = $clog2(BANDS + 1);
	localparam int unsigned AW      = $clog2(BANDS);
	localparam int unsigned PW      = $clog2(WINDOW);
	localparam int unsigned SUM_W   = FLUX_W + PW;
	localparam int unsigned CLR_LEN = (BANDS > WINDOW) ? BANDS : WINDOW;
	localparam int unsigned CW      = $clog2(CLR_LEN);
	localparam int unsigned CMP_W   = (CNT_W > BHIGH_W) ? CNT_W : BHIGH_W;
	localparam int unsigned PROD_W  = FLUX_W + SCALE_W;
	localparam int unsigned THR_W   = PROD_W - SCALE_FRAC;

	// configuration registers
	logic [SCALE_W-1:0] scale_q;
	logic [BLOW_W-1:0]  band_low_q;
	logic [BHIGH_W-1:0] band_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= SCALE_RST;
			band_low_q  <= BAND_LOW_RST;
			band_high_q <= BAND_HIGH_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SCALE:     scale_q     <= cfg_data[SCALE_W-1:0];
				CFG_BAND_LOW:  band_low_q  <= cfg_data[BLOW_W-1:0];
				CFG_BAND_HIGH: band_high_q <= cfg_data[BHIGH_W-1:0];
				default: ;
			endcase
		end
	end

	// clearing pass after reset over both memories
	logic          clr_q;
	logic [CW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == CW'(CLR_LEN - 1)) begin
				clr_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// pipeline flow control: only a result blocked at the output register stalls
	logic res_s4;
	logic out_valid_q;
	logic hold;
	logic adv;
	logic take;

	assign hold       = res_s4 && out_valid_q && !onset.ready;
	assign adv        = !hold;
	assign band.ready = adv && !clr_q;
	assign take       = band.valid && band.ready;

	// accept stage: band index and window check
	logic [CNT_W-1:0] band_cnt_q;
	logic [CMP_W-1:0] idx_cmp;
	logic             in_range;
	logic             in_win;
	logic [AW-1:0]    spec_addr;

	assign idx_cmp   = CMP_W'(band_cnt_q);
	assign in_range  = band_cnt_q < CNT_W'(BANDS);
	assign in_win    = in_range && (idx_cmp >= CMP_W'(band_low_q))
		&& (idx_cmp < CMP_W'(band_high_q));
	assign spec_addr = band_cnt_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_cnt_q <= '0;
		end else if (take) begin
			if (band.data.last_band) begin
				band_cnt_q <= '0;
			end else if (in_range) begin
				band_cnt_q <= band_cnt_q + 1'b1;
			end
		end
	end

	// stage 1 registers
	logic             v_s1;
	logic [MAG_W-1:0] mag_s1;
	logic             last_s1;
	logic             win_s1;
	logic [AW-1:0]    idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mag_s1  <= band.data.band_magnitude;
			last_s1 <= band.data.last_band;
			win_s1  <= in_win;
			idx_s1  <= spec_addr;
		end
	end

	// previous-spectrum memory: read at accept, written back from stage 1
	logic [MAG_W-1:0] spec_mem [BANDS];
	logic [MAG_W-1:0] spec_rd_q;
	logic             spec_we;
	logic [AW-1:0]    spec_waddr;
	logic [MAG_W-1:0] spec_wdata;
	logic             spec_fwd;

	assign spec_we    = clr_q ? ({1'b0, clr_cnt_q} < (CW + 1)'(BANDS))
		: (adv && v_s1 && win_s1);
	assign spec_waddr = clr_q ? clr_cnt_q[AW-1:0] : idx_s1;
	assign spec_wdata = clr_q ? '0 : mag_s1;
	// same band written by the item ahead: bypass the write data
	assign spec_fwd   = v_s1 && win_s1 && (idx_s1 == spec_addr);

	always_ff @(posedge clk) begin
		if (spec_we) begin
			spec_mem[spec_waddr] <= spec_wdata;
		end
		if (take) begin
			if (spec_fwd) begin
				spec_rd_q <= mag_s1;
			end else begin
				spec_rd_q <= spec_mem[spec_addr];
			end
		end
	end

	// stage 1: positive difference into the saturating flux sum
	logic [MAG_W-1:0]  pos_diff;
	logic [FLUX_W:0]   acc_sum;
	logic [FLUX_W-1:0] flux_nxt;
	logic [FLUX_W-1:0] acc_q;

	assign pos_diff = (win_s1 && (mag_s1 > spec_rd_q)) ? (mag_s1 - spec_rd_q) : '0;
	assign acc_sum  = {1'b0, acc_q} + (FLUX_W + 1)'(pos_diff);
	assign flux_nxt = (acc_sum > (FLUX_W + 1)'(FLUX_MAX)) ? FLUX_MAX : acc_sum[FLUX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (adv && v_s1) begin
			acc_q <= last_s1 ? '0 : flux_nxt;
		end
	end

	// stage 2 registers: frame flux
	logic              res_s2;
	logic [FLUX_W-1:0] flux_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= 1'b0;
		end else if (adv) begin
			res_s2 <= v_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1 && last_s1) begin
			flux_s2 <= flux_nxt;
		end
	end

	// stage 2: flux ring and running sum
	logic [FLUX_W-1:0] ring_mem [WINDOW];
	logic [FLUX_W-1:0] ring_rd_q;
	logic [PW-1:0]     ring_ptr_q;
	logic [PW-1:0]     ring_ptr_nxt;
	logic [PW-1:0]     ring_raddr;
	logic              ring_adv;
	logic              ring_we;
	logic [PW-1:0]     ring_waddr;
	logic [FLUX_W-1:0] ring_wdata;
	logic [SUM_W-1:0]  ring_sum_q;
	logic [SUM_W-1:0]  sum_new;

	assign ring_adv     = adv && res_s2;
	assign ring_ptr_nxt = (ring_ptr_q == PW'(WINDOW - 1)) ? '0 : ring_ptr_q + 1'b1;
	// the read always targets the slot of the next frame end
	assign ring_raddr   = ring_adv ? ring_ptr_nxt : ring_ptr_q;
	assign ring_we      = clr_q ? ({1'b0, clr_cnt_q} < (CW + 1)'(WINDOW)) : ring_adv;
	assign ring_waddr   = clr_q ? clr_cnt_q[PW-1:0] : ring_ptr_q;
	assign ring_wdata   = clr_q ? '0 : flux_s2;
	assign sum_new      = ring_sum_q - SUM_W'(ring_rd_q) + SUM_W'(flux_s2);

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= ring_wdata;
		end
		ring_rd_q <= ring_mem[ring_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_ptr_q <= '0;
			ring_sum_q <= '0;
		end else if (ring_adv) begin
			ring_ptr_q <= ring_ptr_nxt;
			ring_sum_q <= sum_new;
		end
	end

	// stage 3 registers: ring mean
	logic              res_s3;
	logic [FLUX_W-1:0] mean_s3;
	logic [FLUX_W-1:0] flux_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s3 <= 1'b0;
		end else if (adv) begin
			res_s3 <= res_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ring_adv) begin
			mean_s3 <= sum_new[SUM_W-1:PW];
			flux_s3 <= flux_s2;
		end
	end

	// stage 4 registers: scaled mean
	logic [PROD_W-1:0] prod_s4;
	logic [FLUX_W-1:0] flux_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s4 <= 1'b0;
		end else if (adv) begin
			res_s4 <= res_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_s3) begin
			prod_s4 <= PROD_W'(mean_s3) * PROD_W'(scale_q);
			flux_s4 <= flux_s3;
		end
	end

	// stage 4: threshold, compare, onset edge
	logic [THR_W-1:0]  thr_full;
	logic [FLUX_W-1:0] thr;
	logic              above;
	logic              onset_q;
	onset_result_t     out_q;

	assign thr_full = prod_s4[PROD_W-1:SCALE_FRAC];
	assign thr      = (thr_full > THR_W'(FLUX_MAX)) ? FLUX_MAX : thr_full[FLUX_W-1:0];
	assign above    = flux_s4 > thr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			onset_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv && res_s4) begin
			onset_q     <= above;
			out_valid_q <= 1'b1;
		end else if (onset.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_s4) begin
			out_q.beat            <= above && !onset_q;
			out_q.flux_value      <= flux_s4;
			out_q.threshold_value <= thr;
		end
	end

	assign onset.valid = out_valid_q;
	assign onset.data  = out_q;

	`SFOD_ASSERT_NOW(a_clear_empty, clr_q, !v_s1 && !res_s2 && !res_s3 && !res_s4 && !out_valid_q, "pipeline busy during clearing pass")
	`SFOD_ASSERT_NEXT(a_frame_end_acc, adv && v_s1 && last_s1, acc_q == '0, "flux sum not cleared at frame end")
	`SFOD_ASSERT_NEXT(a_hold_keeps, hold, res_s4 && $stable(prod_s4) && $stable(flux_s4), "stalled result lost")
	`SFOD_ASSERT_NOW(a_beat_above, onset.valid && onset.data.beat, onset.data.flux_value > onset.data.threshold_value, "beat without flux above threshold")
	`SFOD_ASSERT_NOW(a_cnt_range, band_cnt_q != '0, band_cnt_q <= CNT_W'(BANDS), "band counter beyond spectrum")

endmodule
